@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ hw/rtl/ifl_pkg.sv @@
// types, constants and codes of the forwarding lookup
package ifl_pkg;
	localparam int ROUTE_DEPTH = 1024;
	localparam int ARP_DEPTH   = 16;
	localparam int PORT_BITS   = 4;

	localparam int RIDX_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int RCNT_W = $clog2(ROUTE_DEPTH + 1);
	localparam int AIDX_W = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
	localparam int ACNT_W = $clog2(ARP_DEPTH + 1);

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_ROUTE  = 2'd1;
	localparam logic [1:0] CMD_ARP    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [3:0] ST_BAD_CKS  = 4'd0;
	localparam logic [3:0] ST_TTL_EXP  = 4'd1;
	localparam logic [3:0] ST_UNREACH  = 4'd2;
	localparam logic [3:0] ST_FORWARD  = 4'd3;
	localparam logic [3:0] ST_PENDING  = 4'd4;
	localparam logic [3:0] ST_LOADED   = 4'd5;
	localparam logic [3:0] ST_RT_FULL  = 4'd6;
	localparam logic [3:0] ST_LEARNED  = 4'd7;
	localparam logic [3:0] ST_ARP_FULL = 4'd8;

	typedef struct packed {
		logic [31:0]          pre;
		logic [31:0]          mask;
		logic [31:0]          hop;
		logic [PORT_BITS-1:0] port;
	} rent_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} aent_t;

	// commands from the controller
	typedef struct packed {
		logic       capture;
		logic       srch_init;
		logic       srch_rd;
		logic       srch_cmp;
		logic       scan_init;
		logic       scan_rd;
		logic       scan_cmp;
		logic       arp_wr;
		logic       ins_init;
		logic       ins_rd;
		logic       ins_wr;
		logic       ins_place;
		logic       emit;
		logic [3:0] code;
	} ctl_t;

	// status back to the controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       hdr_ok;
		logic       ttl_low;
		logic       srch_open;
		logic       srch_eq;
		logic       scan_open;
		logic       arp_hit;
		logic       arp_full;
		logic       route_full;
		logic       ins_open;
		logic       ins_gt;
	} sts_t;
endpackage

@@ hw/rtl/ifl_ram.sv @@
// generic single write, single read ram with registered read
module ifl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hw/rtl/ifl_dp.sv @@
// datapath: request registers, route and arp stores, search indexes, result registers
`include "assert_macros.svh"
module ifl_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  ifl_pkg::ctl_t ctl,
	output ifl_pkg::sts_t sts,
	input  logic [1:0]    cmd,
	input  logic [31:0]   dest_ip,
	input  logic [7:0]    ttl_in,
	input  logic [15:0]   checksum_in,
	input  logic          header_ok,
	input  logic [31:0]   route_prefix,
	input  logic [31:0]   route_mask,
	input  logic [31:0]   route_next_hop,
	input  logic [3:0]    route_port,
	input  logic [31:0]   arp_ip,
	input  logic [47:0]   arp_mac,
	output logic          done,
	output logic [3:0]    status,
	output logic [7:0]    ttl_out,
	output logic [15:0]   checksum_out,
	output logic [31:0]   hop_address,
	output logic [3:0]    out_port,
	output logic [47:0]   hop_mac
);
	import ifl_pkg::*;

	logic [1:0]           cmd_q;
	logic [31:0]          dest_q;
	logic [7:0]           ttl_q;
	logic [15:0]          cks_q;
	logic                 hok_q;
	rent_t                new_q;
	aent_t                anew_q;

	logic [RCNT_W-1:0]    rcnt_q;
	logic [RCNT_W-1:0]    lo_q;
	logic [RCNT_W-1:0]    hi_q;
	logic [RCNT_W-1:0]    ins_q;
	logic [ACNT_W-1:0]    acnt_q;
	logic [ACNT_W-1:0]    ai_q;
	logic                 hit_q;
	logic [AIDX_W-1:0]    hidx_q;
	logic [47:0]          mac_q;
	logic [31:0]          hop_q;
	logic [PORT_BITS-1:0] port_q;

	logic                 done_q;
	logic [3:0]           status_q;
	logic [7:0]           ttl_out_q;
	logic [15:0]          cks_out_q;
	logic [31:0]          hop_out_q;
	logic [3:0]           port_out_q;
	logic [47:0]          mac_out_q;

	logic [RCNT_W:0]      msum;
	logic [RIDX_W-1:0]    mid;
	logic [RCNT_W-1:0]    ins_dec;
	logic [31:0]          key;
	logic [31:0]          target;
	rent_t                rrd;
	aent_t                ard;
	logic                 r_we;
	logic [RIDX_W-1:0]    r_raddr;
	rent_t                r_wdata;
	logic                 a_we;
	logic [AIDX_W-1:0]    a_waddr;
	logic                 a_eq;
	logic                 lookup_ok;
	logic                 with_route;

	assign msum    = {1'b0, lo_q} + {1'b0, hi_q} - {{RCNT_W{1'b0}}, 1'b1};
	assign mid     = msum[RIDX_W:1];
	assign ins_dec = ins_q - {{(RCNT_W-1){1'b0}}, 1'b1};
	assign r_raddr = ctl.ins_rd ? ins_dec[RIDX_W-1:0] : mid;
	assign key     = dest_q & rrd.mask;
	assign target  = (cmd_q == CMD_LOOKUP) ? hop_q : anew_q.ip;
	assign a_eq    = (ard.ip == target);

	assign sts.cmd        = cmd_q;
	assign sts.hdr_ok     = hok_q;
	assign sts.ttl_low    = (ttl_q <= 8'd1);
	assign sts.srch_open  = (lo_q < hi_q);
	assign sts.srch_eq    = (rrd.pre == key);
	assign sts.scan_open  = (ai_q < acnt_q);
	assign sts.arp_hit    = hit_q;
	assign sts.arp_full   = (acnt_q == ACNT_W'(ARP_DEPTH));
	assign sts.route_full = (rcnt_q == RCNT_W'(ROUTE_DEPTH));
	assign sts.ins_open   = (ins_q != '0);
	assign sts.ins_gt     = (rrd.pre > new_q.pre);

	assign r_we    = ctl.ins_wr | ctl.ins_place;
	assign r_wdata = (ctl.ins_wr && sts.ins_gt) ? rrd : new_q;
	assign a_we    = ctl.arp_wr;
	assign a_waddr = hit_q ? hidx_q : acnt_q[AIDX_W-1:0];

	ifl_ram #(.WIDTH($bits(rent_t)), .DEPTH(ROUTE_DEPTH)) u_route_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (ins_q[RIDX_W-1:0]),
		.wdata (r_wdata),
		.re    (ctl.srch_rd | ctl.ins_rd),
		.raddr (r_raddr),
		.rdata (rrd)
	);

	ifl_ram #(.WIDTH($bits(aent_t)), .DEPTH(ARP_DEPTH)) u_arp_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (anew_q),
		.re    (ctl.scan_rd),
		.raddr (ai_q[AIDX_W-1:0]),
		.rdata (ard)
	);

	// request payload
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q       <= cmd;
			dest_q      <= dest_ip;
			ttl_q       <= ttl_in;
			cks_q       <= checksum_in;
			hok_q       <= header_ok;
			new_q.pre   <= route_prefix;
			new_q.mask  <= route_mask;
			new_q.hop   <= route_next_hop;
			new_q.port  <= route_port[PORT_BITS-1:0];
			anew_q.ip   <= arp_ip;
			anew_q.mac  <= arp_mac;
		end
	end

	// counts and walk indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			acnt_q <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
			ins_q  <= '0;
			ai_q   <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (ctl.srch_init) begin
				lo_q <= '0;
				hi_q <= rcnt_q;
			end else if (ctl.srch_cmp && !sts.srch_eq) begin
				if (rrd.pre < key) begin
					lo_q <= RCNT_W'(mid) + {{(RCNT_W-1){1'b0}}, 1'b1};
				end else begin
					hi_q <= RCNT_W'(mid);
				end
			end
			if (ctl.ins_init) begin
				ins_q <= rcnt_q;
			end else if (ctl.ins_wr && sts.ins_gt) begin
				ins_q <= ins_dec;
			end
			if ((ctl.ins_wr && !sts.ins_gt) || ctl.ins_place) begin
				rcnt_q <= rcnt_q + {{(RCNT_W-1){1'b0}}, 1'b1};
			end
			if (ctl.scan_init) begin
				ai_q  <= '0;
				hit_q <= 1'b0;
			end else if (ctl.scan_cmp) begin
				ai_q <= ai_q + {{(ACNT_W-1){1'b0}}, 1'b1};
				if (a_eq) begin
					hit_q <= 1'b1;
				end
			end
			if (ctl.arp_wr && !hit_q) begin
				acnt_q <= acnt_q + {{(ACNT_W-1){1'b0}}, 1'b1};
			end
		end
	end

	// matched route and arp entry
	always_ff @(posedge clk) begin
		if (ctl.srch_cmp && sts.srch_eq) begin
			hop_q  <= rrd.hop;
			port_q <= rrd.port;
		end
		if (ctl.scan_cmp && a_eq) begin
			hidx_q <= ai_q[AIDX_W-1:0];
			mac_q  <= ard.mac;
		end
	end

	assign lookup_ok  = (ctl.code == ST_UNREACH) || (ctl.code == ST_FORWARD) ||
	                    (ctl.code == ST_PENDING);
	assign with_route = (ctl.code == ST_FORWARD) || (ctl.code == ST_PENDING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			status_q   <= ctl.code;
			ttl_out_q  <= lookup_ok ? ttl_q - 8'd1 : '0;
			cks_out_q  <= lookup_ok ? cks_q + 16'd1 : '0;
			hop_out_q  <= with_route ? hop_q : '0;
			port_out_q <= with_route ? 4'(port_q) : '0;
			mac_out_q  <= (ctl.code == ST_FORWARD) ? mac_q : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign ttl_out      = ttl_out_q;
	assign checksum_out = cks_out_q;
	assign hop_address  = hop_out_q;
	assign out_port     = port_out_q;
	assign hop_mac      = mac_out_q;

	`ASSERT_NEVER(a_rcnt_range, clk, arst_n, rcnt_q > RCNT_W'(ROUTE_DEPTH), "route count overflow")
	`ASSERT_NEVER(a_acnt_range, clk, arst_n, acnt_q > ACNT_W'(ARP_DEPTH), "arp count overflow")
	`ASSERT_HOLDS(a_srch_window, clk, arst_n, ctl.srch_rd |=> lo_q < hi_q, "search window empty")
endmodule

@@ hw/rtl/ifl_ctrl.sv @@
// controller state machine of the forwarding lookup
module ifl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ifl_pkg::sts_t sts,
	output ifl_pkg::ctl_t ctl
);
	import ifl_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SRCH     = 4'd2;
	localparam logic [3:0] S_SRCH_CMP = 4'd3;
	localparam logic [3:0] S_SCAN     = 4'd4;
	localparam logic [3:0] S_SCAN_CMP = 4'd5;
	localparam logic [3:0] S_INS      = 4'd6;
	localparam logic [3:0] S_INS_WR   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				case (sts.cmd)
					CMD_LOOKUP: begin
						if (!sts.hdr_ok) begin
							ctl.emit = 1'b1;
							ctl.code = ST_BAD_CKS;
						end else if (sts.ttl_low) begin
							ctl.emit = 1'b1;
							ctl.code = ST_TTL_EXP;
						end else begin
							ctl.srch_init = 1'b1;
							state_d       = S_SRCH;
						end
					end
					CMD_ROUTE: begin
						if (sts.route_full) begin
							ctl.emit = 1'b1;
							ctl.code = ST_RT_FULL;
						end else begin
							ctl.ins_init = 1'b1;
							state_d      = S_INS;
						end
					end
					CMD_ARP: begin
						ctl.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SRCH: begin
				if (sts.srch_open) begin
					ctl.srch_rd = 1'b1;
					state_d     = S_SRCH_CMP;
				end else begin
					ctl.emit = 1'b1;
					ctl.code = ST_UNREACH;
					state_d  = S_IDLE;
				end
			end
			S_SRCH_CMP: begin
				ctl.srch_cmp = 1'b1;
				if (sts.srch_eq) begin
					ctl.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_SCAN: begin
				if (sts.scan_open) begin
					ctl.scan_rd = 1'b1;
					state_d     = S_SCAN_CMP;
				end else begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
					if (sts.cmd == CMD_LOOKUP) begin
						ctl.code = sts.arp_hit ? ST_FORWARD : ST_PENDING;
					end else if (sts.arp_hit || !sts.arp_full) begin
						ctl.arp_wr = 1'b1;
						ctl.code   = ST_LEARNED;
					end else begin
						ctl.code = ST_ARP_FULL;
					end
				end
			end
			S_SCAN_CMP: begin
				ctl.scan_cmp = 1'b1;
				state_d      = S_SCAN;
			end
			S_INS: begin
				if (sts.ins_open) begin
					ctl.ins_rd = 1'b1;
					state_d    = S_INS_WR;
				end else begin
					ctl.ins_place = 1'b1;
					ctl.emit      = 1'b1;
					ctl.code      = ST_LOADED;
					state_d       = S_IDLE;
				end
			end
			S_INS_WR: begin
				ctl.ins_wr = 1'b1;
				if (sts.ins_gt) begin
					state_d = S_INS;
				end else begin
					ctl.emit = 1'b1;
					ctl.code = ST_LOADED;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ hw/rtl/ipv4_forwarding_lookup.sv @@
// top level of the ipv4 route and arp lookup block
//
//   channel   | handshake        | payload
//   ----------+------------------+---------------------------------------------
//   request   | start / busy     | cmd, dest_ip, ttl_in, checksum_in, header_ok,
//             |                  | route_*, arp_ip, arp_mac
//   result    | done (1 cycle)   | status, ttl_out, checksum_out, hop_address,
//             |                  | out_port, hop_mac
//
// one request at a time; busy is high from the cycle after acceptance until the result
// a lookup binary searches the routes (at most 1 + log2 of the route count probes)
//   and on a match scans every arp entry held (up to 16); a failed check skips both
// a route load shifts up each entry with a larger prefix, then places the new one
// an arp reply scans every arp entry held; unknown commands free busy with no result
// the route store is a single write, single read ram: a probe reads, then compares
// reset clears the counts, no clearing pass; the receiver takes done without stall
`include "assert_macros.svh"
module ipv4_forwarding_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] dest_ip,
	input  logic [7:0]  ttl_in,
	input  logic [15:0] checksum_in,
	input  logic        header_ok,
	input  logic [31:0] route_prefix,
	input  logic [31:0] route_mask,
	input  logic [31:0] route_next_hop,
	input  logic [3:0]  route_port,
	input  logic [31:0] arp_ip,
	input  logic [47:0] arp_mac,
	output logic        done,
	output logic [3:0]  status,
	output logic [7:0]  ttl_out,
	output logic [15:0] checksum_out,
	output logic [31:0] hop_address,
	output logic [3:0]  out_port,
	output logic [47:0] hop_mac
);
	import ifl_pkg::*;

	// command and status between controller and datapath
	ctl_t ctl;
	sts_t sts;

	ifl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	ifl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cmd            (cmd),
		.dest_ip        (dest_ip),
		.ttl_in         (ttl_in),
		.checksum_in    (checksum_in),
		.header_ok      (header_ok),
		.route_prefix   (route_prefix),
		.route_mask     (route_mask),
		.route_next_hop (route_next_hop),
		.route_port     (route_port),
		.arp_ip         (arp_ip),
		.arp_mac        (arp_mac),
		.done           (done),
		.status         (status),
		.ttl_out        (ttl_out),
		.checksum_out   (checksum_out),
		.hop_address    (hop_address),
		.out_port       (out_port),
		.hop_mac        (hop_mac)
	);

	// a result always closes a request that was in flight
	`ASSERT_HOLDS(a_done_after_busy, clk, arst_n, done |-> $past(busy), "result without request")
	// a result lasts one cycle
	`ASSERT_HOLDS(a_done_single, clk, arst_n, done |=> !done, "result held two cycles")
	// the block is free again when a result shows
	`ASSERT_HOLDS(a_done_idle, clk, arst_n, done |-> !busy, "busy while showing result")
endmodule
